FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an active-low reset that disables it.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check on the default clk / rst_n names.
`define ASSERT_STD(label, prop, msg) \
    `ASSERT_CLK(label, clk, rst_n, prop, msg)

`endif

FILE: hdl/fdf_pkg.sv
// Constants and codes for the flood duplicate filter.
package fdf_pkg;

    // History ring
    localparam int HISTORY_DEPTH = 10;
    localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int ENTRY_W = 32;

    // Config port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_OWN_ID = 1'b0;

    // Result actions
    localparam logic [1:0] ACT_DUPLICATE = 2'd0;
    localparam logic [1:0] ACT_NOT_NEIGHBOR = 2'd1;
    localparam logic [1:0] ACT_ORIGINATE = 2'd2;
    localparam logic [1:0] ACT_DELIVER = 2'd3;

    typedef logic [PTR_W-1:0] ptr_t;

endpackage

FILE: hdl/flood_duplicate_filter.sv
// Top level: flood packet duplicate filter with ring history in RAM.
//
//  channel   signals                                         handshake
//  -------   ----------------------------------------------  ------------------------
//  input     origin_node signature deliver_port previous_hop  start && !busy
//  result    action hop_low hop_high write_hop_high           done, one cycle
//            local_port originated_count delivered_count
//  config    psel penable pwrite paddr pwdata prdata pready   psel&penable&pwrite
//
// An item passes the scan, wait and decide states: the history RAM read port is
// stepped through one entry per cycle, the wait state drains the read latency,
// and the decide state decides and writes back a delivered or originated item.
// The result beat comes the cycle after that, and busy is already low then.
// Valid marks sit in flip-flops that reset clears at once, so no clearing pass
// is needed. The receiver cannot stall; results are never held back.
module flood_duplicate_filter (
    input  logic                         clk,
    input  logic                         rst_n,
    // input beat
    input  logic                         start,
    output logic                         busy,
    input  logic [15:0]                  origin_node,
    input  logic [15:0]                  signature,
    input  logic [7:0]                   deliver_port,
    input  logic [7:0]                   previous_hop,
    // result beat
    output logic                         done,
    output logic [1:0]                   action,
    output logic [7:0]                   hop_low,
    output logic [7:0]                   hop_high,
    output logic                         write_hop_high,
    output logic [7:0]                   local_port,
    output logic [15:0]                  originated_count,
    output logic [15:0]                  delivered_count,
    // config port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fdf_pkg::ADDR_W-1:0]   paddr,
    input  logic [fdf_pkg::DATA_W-1:0]   pwdata,
    output logic [fdf_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    import fdf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_DECIDE = 2'd3;

    localparam ptr_t LAST_IDX = PTR_W'(HISTORY_DEPTH - 1);

    logic [1:0]               state_reg, state_next;
    ptr_t                     idx_reg, idx_next;
    ptr_t                     pend_idx_reg;
    logic                     pend_reg, pend_next;
    logic                     hit_reg, hit_next;
    ptr_t                     wptr_reg;
    logic [HISTORY_DEPTH-1:0] valid_reg;
    logic [15:0]              own_id_reg;
    logic [15:0]              orig_cnt_reg;
    logic [15:0]              dlv_cnt_reg;

    // latched item
    logic [15:0]              org_reg;
    logic [15:0]              sig_reg;
    logic [7:0]               port_reg;
    logic [7:0]               prev_reg;

    // result registers
    logic                     done_reg;
    logic [1:0]               action_reg;
    logic [7:0]               hop_low_reg;
    logic [7:0]               hop_high_reg;
    logic                     wr_high_reg;
    logic [7:0]               lport_reg;

    logic                     accept;
    logic                     cfg_wr;
    logic [ENTRY_W-1:0]       rd_data;
    logic                     ram_we;
    logic                     is_own;
    logic                     is_neighbor;
    logic [1:0]               act_sel;

    assign accept = start && (state_reg == ST_IDLE);
    assign cfg_wr = psel && penable && pwrite;

    // History RAM: {origin, signature} per ring slot
    fdf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wptr_reg),
        .wdata ({org_reg, sig_reg}),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    // Decision on the latched item, used in the decide cycle
    assign is_own = (org_reg == own_id_reg);
    assign is_neighbor = ({9'd0, prev_reg} + 17'd1 == {1'b0, own_id_reg})
                      || ({9'd0, prev_reg} == {1'b0, own_id_reg} + 17'd1);

    always_comb
    begin
        if (hit_reg)
        begin
            act_sel = ACT_DUPLICATE;
        end
        else if (is_own)
        begin
            act_sel = ACT_ORIGINATE;
        end
        else if (is_neighbor)
        begin
            act_sel = ACT_DELIVER;
        end
        else
        begin
            act_sel = ACT_NOT_NEIGHBOR;
        end
    end

    assign ram_we = (state_reg == ST_DECIDE)
                 && (act_sel == ACT_ORIGINATE || act_sel == ACT_DELIVER);

    // Scan sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        pend_next = 1'b0;
        hit_next = hit_reg;
        if (pend_reg && valid_reg[pend_idx_reg] && (rd_data == {org_reg, sig_reg}))
        begin
            hit_next = 1'b1;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                    idx_next = '0;
                    hit_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                pend_next = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    idx_next = idx_reg + PTR_W'(1);
                end
            end
            ST_WAIT:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg <= '0;
            pend_idx_reg <= '0;
            pend_reg <= 1'b0;
            hit_reg <= 1'b0;
            wptr_reg <= '0;
            valid_reg <= '0;
            own_id_reg <= 16'd0;
            orig_cnt_reg <= 16'd0;
            dlv_cnt_reg <= 16'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            pend_idx_reg <= idx_reg;
            pend_reg <= pend_next;
            hit_reg <= hit_next;
            done_reg <= (state_reg == ST_DECIDE);
            if (cfg_wr && (paddr[ADDR_W-1] == REG_OWN_ID))
            begin
                own_id_reg <= pwdata[15:0];
            end
            if (ram_we)
            begin
                valid_reg[wptr_reg] <= 1'b1;
                wptr_reg <= (wptr_reg == LAST_IDX) ? '0 : wptr_reg + PTR_W'(1);
            end
            if (state_reg == ST_DECIDE && act_sel == ACT_ORIGINATE)
            begin
                orig_cnt_reg <= orig_cnt_reg + 16'd1;
            end
            if (state_reg == ST_DECIDE && act_sel == ACT_DELIVER)
            begin
                dlv_cnt_reg <= dlv_cnt_reg + 16'd1;
            end
        end
    end

    // Item latch and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            org_reg <= origin_node;
            sig_reg <= signature;
            port_reg <= deliver_port;
            prev_reg <= previous_hop;
        end
        if (state_reg == ST_DECIDE)
        begin
            action_reg <= act_sel;
            hop_low_reg <= (act_sel == ACT_ORIGINATE || act_sel == ACT_DELIVER)
                         ? own_id_reg[7:0] : 8'd0;
            hop_high_reg <= (act_sel == ACT_ORIGINATE) ? own_id_reg[15:8] : 8'd0;
            wr_high_reg <= (act_sel == ACT_ORIGINATE);
            lport_reg <= (act_sel == ACT_DELIVER) ? port_reg : 8'd0;
        end
    end

    // Outputs
    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign action = action_reg;
    assign hop_low = hop_low_reg;
    assign hop_high = hop_high_reg;
    assign write_hop_high = wr_high_reg;
    assign local_port = lport_reg;
    assign originated_count = orig_cnt_reg;
    assign delivered_count = dlv_cnt_reg;
    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1] == REG_OWN_ID)
                  ? {{(DATA_W - 16){1'b0}}, own_id_reg} : '0;

endmodule

FILE: hdl/fdf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fdf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/fdf_checker.sv
// Port-level checker for the flood duplicate filter, bound to the top level.
`include "assert_macros.svh"

module fdf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [1:0]  action,
    input logic        write_hop_high,
    input logic [15:0] originated_count,
    input logic [15:0] delivered_count
);

    import fdf_pkg::*;

    // an accepted beat keeps the block busy until its result
    `ASSERT_STD(a_accept_busy, (start && !busy) |=> busy, "accept did not raise busy")

    // a result beat lands only once the block is free again
    `ASSERT_STD(a_done_idle, done |-> !busy, "result while busy")

    // one result per item: strobes never come back to back
    `ASSERT_STD(a_done_single, done |=> !done, "repeated result beat")

    // origination bumps its counter and rewrites the high hop byte
    `ASSERT_STD(a_orig_count,
        (done && action == ACT_ORIGINATE) |->
            (write_hop_high && originated_count == $past(originated_count) + 16'd1),
        "originate result without count step")

    // the delivered counter moves only on a delivery result beat
    `ASSERT_STD(a_dlv_stable,
        !(done && action == ACT_DELIVER) |-> (delivered_count == $past(delivered_count)),
        "delivered count moved without delivery")

endmodule

bind flood_duplicate_filter fdf_checker u_fdf_checker (.*);

FILE: bench/testbench.sv
// Self-checking testbench for the flood duplicate filter.
`timescale 1ns / 100ps

module testbench;
    import fdf_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int ITEMS_PER_PHASE = 120;

    // One result beat as the block reports it
    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  hop_low;
        logic [7:0]  hop_high;
        logic        write_hop_high;
        logic [7:0]  local_port;
        logic [15:0] originated_count;
        logic [15:0] delivered_count;
    } verdict_t;

    // Tracks the history ring and counters, predicts each verdict
    class dup_filter_scoreboard;
        logic [15:0] own_id;
        logic        seen_valid [HISTORY_DEPTH];
        logic [15:0] seen_origin [HISTORY_DEPTH];
        logic [15:0] seen_sig [HISTORY_DEPTH];
        int          ring_slot;
        logic [15:0] origin_cnt;
        logic [15:0] deliver_cnt;
        verdict_t    pending_verdicts [$];
        int          error_count;

        function new();
            own_id = '0;
            foreach (seen_valid[i])
            begin
                seen_valid[i] = 1'b0;
                seen_origin[i] = '0;
                seen_sig[i] = '0;
            end
            ring_slot = 0;
            origin_cnt = '0;
            deliver_cnt = '0;
            error_count = 0;
        endfunction

        function void set_own_id(logic [15:0] id);
            own_id = id;
        endfunction

        function int pending();
            return pending_verdicts.size();
        endfunction

        function void remember(logic [15:0] org, logic [15:0] sig);
            seen_valid[ring_slot] = 1'b1;
            seen_origin[ring_slot] = org;
            seen_sig[ring_slot] = sig;
            ring_slot = (ring_slot + 1) % HISTORY_DEPTH;
        endfunction

        // Accepted header beat: work out its verdict and queue it
        function void note_header(logic [15:0] org, logic [15:0] sig,
                                  logic [7:0] port, logic [7:0] prev);
            verdict_t v;
            logic seen;
            int unsigned hop;
            int unsigned me;
            v = '0;
            seen = 1'b0;
            hop = 32'(prev);
            me = 32'(own_id);
            foreach (seen_valid[i])
                if (seen_valid[i] && seen_origin[i] == org && seen_sig[i] == sig)
                    seen = 1'b1;
            if (seen)
                v.action = ACT_DUPLICATE;
            else if (org == own_id)
            begin
                remember(org, sig);
                origin_cnt++;
                v.action = ACT_ORIGINATE;
                v.hop_low = own_id[7:0];
                v.hop_high = own_id[15:8];
                v.write_hop_high = 1'b1;
            end
            // neighbor test on plain integers, no wrap
            else if (hop + 1 == me || hop == me + 1)
            begin
                remember(org, sig);
                deliver_cnt++;
                v.action = ACT_DELIVER;
                v.hop_low = own_id[7:0];
                v.local_port = port;
            end
            else
                v.action = ACT_NOT_NEIGHBOR;
            v.originated_count = origin_cnt;
            v.delivered_count = deliver_cnt;
            pending_verdicts.push_back(v);
        endfunction

        function void compare_field(string name, int unsigned exp, int unsigned got);
            if (exp != got)
            begin
                $error("%s: expected %0h, got %0h", name, exp, got);
                error_count++;
            end
        endfunction

        // Result beat: compare with the oldest queued verdict
        function void check_result(verdict_t got);
            verdict_t exp;
            if (pending_verdicts.size() == 0)
            begin
                $error("result beat with no header outstanding");
                error_count++;
                return;
            end
            exp = pending_verdicts.pop_front();
            compare_field("action", 32'(exp.action), 32'(got.action));
            compare_field("hop_low", 32'(exp.hop_low), 32'(got.hop_low));
            compare_field("hop_high", 32'(exp.hop_high), 32'(got.hop_high));
            compare_field("write_hop_high", 32'(exp.write_hop_high),
                          32'(got.write_hop_high));
            compare_field("local_port", 32'(exp.local_port), 32'(got.local_port));
            compare_field("originated_count", 32'(exp.originated_count),
                          32'(got.originated_count));
            compare_field("delivered_count", 32'(exp.delivered_count),
                          32'(got.delivered_count));
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [15:0]       origin_node;
    logic [15:0]       signature;
    logic [7:0]        deliver_port;
    logic [7:0]        previous_hop;
    logic              done;
    logic [1:0]        action;
    logic [7:0]        hop_low;
    logic [7:0]        hop_high;
    logic              write_hop_high;
    logic [7:0]        local_port;
    logic [15:0]       originated_count;
    logic [15:0]       delivered_count;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    dup_filter_scoreboard sb;
    int                   cycle_count;
    logic                 no_idle;
    logic [15:0]          origin_pool [4];

    flood_duplicate_filter dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .origin_node      (origin_node),
        .signature        (signature),
        .deliver_port     (deliver_port),
        .previous_hop     (previous_hop),
        .done             (done),
        .action           (action),
        .hop_low          (hop_low),
        .hop_high         (hop_high),
        .write_hop_high   (write_hop_high),
        .local_port       (local_port),
        .originated_count (originated_count),
        .delivered_count  (delivered_count),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result monitor; the receiver never stalls
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result({action, hop_low, hop_high, write_hop_high, local_port,
                             originated_count, delivered_count});
    end

    // Sender idle length: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 40)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 4);
        else if (r < 95)
            return $urandom_range(5, 14);
        return $urandom_range(15, 40);
    endfunction

    // Present one header beat and hold it until accepted
    task automatic send_header(input logic [15:0] org, input logic [15:0] sig,
                               input logic [7:0] port, input logic [7:0] prev);
        int gap;
        start <= 1'b1;
        origin_node <= org;
        signature <= sig;
        deliver_port <= port;
        previous_hop <= prev;
        do
            @(posedge clk);
        while (busy);
        sb.note_header(org, sig, port, prev);
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop start and let every outstanding verdict come back
    task automatic wait_idle();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic apb_write(input int idx, input logic [DATA_W-1:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * idx);
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == int'(REG_OWN_ID))
            sb.set_own_id(data[15:0]);
    endtask

    // Read back the own id register
    task automatic apb_check_own_id();
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_W'(4 * int'(REG_OWN_ID));
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[15:0] !== sb.own_id)
        begin
            $error("own_node_id: expected %0h, got %0h", sb.own_id, prdata[15:0]);
            sb.error_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // New own id, then random headers mostly from a few known sources
    task automatic run_phase(input logic [15:0] id, input int count);
        logic [15:0] org;
        logic [15:0] sig;
        logic [7:0]  prev;
        int          r;
        wait_idle();
        // a write past the last register must be ignored
        if ($urandom_range(0, 1))
            apb_write(1, $urandom);
        apb_write(int'(REG_OWN_ID), {16'h0000, id});
        apb_check_own_id();
        foreach (origin_pool[i])
            origin_pool[i] = 16'($urandom_range(0, 65535));
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 25)
                org = id;
            else if (r < 80)
                org = origin_pool[$urandom_range(0, 3)];
            else
                org = 16'($urandom_range(0, 65535));
            if ($urandom_range(0, 99) < 70)
                sig = 16'($urandom_range(0, 7));
            else
                sig = 16'($urandom_range(0, 65535));
            r = $urandom_range(0, 99);
            if (r < 30)
                prev = id[7:0] - 8'd1;
            else if (r < 60)
                prev = id[7:0] + 8'd1;
            else
                prev = 8'($urandom_range(0, 255));
            send_header(org, sig, 8'($urandom_range(0, 255)), prev);
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        sb = new();
        cycle_count = 0;
        no_idle = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        origin_node = '0;
        signature = '0;
        deliver_port = '0;
        previous_hop = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part with own id 0
        apb_write(int'(REG_OWN_ID), 32'h0000_0000);
        apb_check_own_id();
        send_header(16'h0000, 16'h0000, 8'h00, 8'h00);   // originate
        send_header(16'h0000, 16'h0000, 8'h00, 8'h00);   // own packet seen again
        send_header(16'h1234, 16'hFFFF, 8'hFF, 8'h01);   // own id plus one
        send_header(16'h1234, 16'hFFFF, 8'hFF, 8'h01);   // duplicate
        send_header(16'h1234, 16'hFFFE, 8'h12, 8'h02);   // not a neighbor
        send_header(16'hFFFF, 16'hFFFF, 8'hAA, 8'hFF);   // own id minus one has no byte
        send_header(16'hFFFF, 16'h0000, 8'h55, 8'h01);
        // overflow the history so the oldest entries get overwritten
        for (int i = 1; i <= HISTORY_DEPTH; i++)
            send_header(16'h0000, 16'(i), 8'(i), 8'h00);
        send_header(16'h0000, 16'h0000, 8'h00, 8'h00);   // evicted, new again
        send_header(16'h1234, 16'hFFFF, 8'hFF, 8'h01);   // evicted, new again
        send_header(16'h0000, 16'd10, 8'h00, 8'h00);     // still held

        // Random phases over several own ids, extremes included
        run_phase(16'h0001, ITEMS_PER_PHASE);
        run_phase(16'h00FF, ITEMS_PER_PHASE);
        run_phase(16'h0100, ITEMS_PER_PHASE);
        run_phase(16'hFFFF, ITEMS_PER_PHASE);
        run_phase(16'h0000, ITEMS_PER_PHASE);
        run_phase(16'($urandom_range(2, 254)), ITEMS_PER_PHASE);
        run_phase(16'($urandom_range(257, 65534)), ITEMS_PER_PHASE);

        wait_idle();
        repeat (30) @(posedge clk);
        if (sb.error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
